@@ rtl/core/echo_comb_and_clip_effect_core_macros.svh @@
// ----------------------------------------------------------------------------
// echo_comb_and_clip_effect_core_macros
// assertion macros shared by the echo and clip core
// ----------------------------------------------------------------------------
`ifndef ECHO_COMB_AND_CLIP_EFFECT_CORE_MACROS_SVH
`define ECHO_COMB_AND_CLIP_EFFECT_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define ECCL_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define ECCL_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/eccl_pkg.sv @@
// ----------------------------------------------------------------------------
// eccl_pkg
// shared constants, control types and helpers of the echo and clip core
// ----------------------------------------------------------------------------
package eccl_pkg;

    // default build values
    localparam int unsigned ECCL_DEPTH_DEF       = 4096;
    localparam int unsigned ECCL_SAMPLE_BITS_DEF = 24;

    // fixed field widths
    localparam int unsigned MODE_BITS    = 3;
    localparam int unsigned DELAY_BITS   = 12;
    localparam int unsigned INTENS_BITS  = 16;
    localparam int unsigned POS_BITS     = 13;
    localparam int unsigned CFG_IDX_BITS = 2;
    localparam int unsigned CFG_DATA_BITS = 16;

    // reciprocal precision of the delay wrap
    localparam int unsigned RECIP_BITS   = 2 * DELAY_BITS;

    // block position saturates here
    localparam logic [POS_BITS-1:0] POS_MAX = 13'd8191;

    // gain scaling shifts for echo and reverb
    localparam int unsigned ECHO_SHIFT = 15;
    localparam int unsigned REV_SHIFT  = 16;

    // effect mode codes
    localparam logic [MODE_BITS-1:0] MODE_REVERB = 3'd1;
    localparam logic [MODE_BITS-1:0] MODE_ECHO   = 3'd2;
    localparam logic [MODE_BITS-1:0] MODE_COMP   = 3'd3;
    localparam logic [MODE_BITS-1:0] MODE_LIMIT  = 3'd4;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_MODE      = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DELAY     = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_INTENSITY = 2'd2;

    // per-sample control carried into the arithmetic stage
    typedef struct packed {
        logic echo_on;    // add the delayed term
        logic half_gain;  // reverb: gain halved
        logic use_self;   // zero delay: current sample is the delayed value
        logic clip_on;    // compressor or limiter clipping
    } t_s2_ctl;

    // delay reduced modulo the line depth by a reciprocal multiply, exact for
    // every delay code; a depth above the delay range gives a zero quotient,
    // so only the low bits of the depth are needed
    function automatic logic [DELAY_BITS-1:0] delay_wrap(
        input logic [DELAY_BITS-1:0] d,
        input logic [DELAY_BITS-1:0] depth_lo,
        input logic [RECIP_BITS-1:0] recip
    );
        logic [DELAY_BITS+RECIP_BITS-1:0] prod;
        logic [DELAY_BITS-1:0]            quot;
        logic [2*DELAY_BITS-1:0]          back;
        prod = d * recip;
        quot = prod[DELAY_BITS+RECIP_BITS-1:RECIP_BITS];
        back = quot * depth_lo;
        return d - back[DELAY_BITS-1:0];
    endfunction

endpackage

@@ rtl/core/eccl_delay_mem.sv @@
// ----------------------------------------------------------------------------
// eccl_delay_mem
// delay line storage: one write and one registered read per cycle, with
// write-to-read bypass when both hit the same entry on the same edge
// ----------------------------------------------------------------------------
module eccl_delay_mem import eccl_pkg::*; #(
    parameter int unsigned DEPTH = ECCL_DEPTH_DEF,
    parameter int unsigned WIDTH = ECCL_SAMPLE_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_rd_en,
    input  logic [$clog2(DEPTH)-1:0]  i_rd_addr,
    input  logic                      i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]  i_wr_addr,
    input  logic [WIDTH-1:0]          i_wr_data,
    output logic [WIDTH-1:0]          o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;
    logic [WIDTH-1:0] r_byp_data;
    logic             r_byp;

    // storage write
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read, old data on a same-entry collision
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data  <= r_mem[i_rd_addr];
            r_byp_data <= i_wr_data;
        end
    end

    // bypass flag for a collision on the read edge
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp <= 1'b0;
        end else if (i_rd_en) begin
            r_byp <= i_wr_en && (i_wr_addr == i_rd_addr);
        end
    end

    assign o_rd_data = r_byp ? r_byp_data : r_rd_data;

endmodule

@@ rtl/core/eccl_seq.sv @@
// ----------------------------------------------------------------------------
// eccl_seq
// input stage: write index and block position, delay line read address,
// mode decode and the holding register of the arithmetic stage
// ----------------------------------------------------------------------------
`include "echo_comb_and_clip_effect_core_macros.svh"

module eccl_seq import eccl_pkg::*; #(
    parameter int unsigned DELAY_DEPTH = ECCL_DEPTH_DEF,
    parameter int unsigned SAMPLE_BITS = ECCL_SAMPLE_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_acc,
    input  logic                            i_move,
    input  logic signed [SAMPLE_BITS-1:0]   i_sample,
    input  logic                            i_block_start,
    input  logic [MODE_BITS-1:0]            i_mode,
    input  logic [DELAY_BITS-1:0]           i_delay,
    input  logic [$clog2(DELAY_DEPTH)-1:0]  i_dmod,
    output logic [$clog2(DELAY_DEPTH)-1:0]  o_rd_addr,
    output logic                            o_s2_valid,
    output logic signed [SAMPLE_BITS-1:0]   o_s2_sample,
    output t_s2_ctl                         o_s2_ctl,
    output logic [$clog2(DELAY_DEPTH)-1:0]  o_s2_wr_addr
);

    localparam int unsigned AW = $clog2(DELAY_DEPTH);

    logic [AW-1:0]                 r_wr_idx;
    logic [AW-1:0]                 n_wr_idx;
    logic [POS_BITS-1:0]           r_pos;
    logic [POS_BITS-1:0]           n_pos;
    logic [POS_BITS-1:0]           pos_cur;
    logic                          r_s2_valid;
    logic                          n_s2_valid;
    logic signed [SAMPLE_BITS-1:0] r_s2_sample;
    t_s2_ctl                       r_s2_ctl;
    t_s2_ctl                       n_s2_ctl;
    logic [AW-1:0]                 r_s2_wr_addr;
    logic [AW:0]                   wr_ext;
    logic [AW:0]                   dmod_ext;
    logic                          echo_mode;
    logic                          clip_mode;

    // position within the block and next write slot
    always_comb begin
        pos_cur  = i_block_start ? '0 : r_pos;
        n_pos    = (pos_cur == POS_MAX) ? POS_MAX : pos_cur + 1'b1;
        n_wr_idx = (r_wr_idx == AW'(DELAY_DEPTH - 1)) ? '0 : r_wr_idx + 1'b1;
    end

    // read address: write slot minus the wrapped delay
    always_comb begin
        wr_ext   = {1'b0, r_wr_idx};
        dmod_ext = {1'b0, i_dmod};
        if (r_wr_idx >= i_dmod) begin
            o_rd_addr = AW'(wr_ext - dmod_ext);
        end else begin
            o_rd_addr = AW'(wr_ext + (AW + 1)'(DELAY_DEPTH) - dmod_ext);
        end
    end

    // mode decode for the arithmetic stage
    always_comb begin
        echo_mode          = i_mode inside {MODE_REVERB, MODE_ECHO};
        clip_mode          = i_mode inside {MODE_COMP, MODE_LIMIT};
        n_s2_ctl.echo_on   = echo_mode && (pos_cur >= POS_BITS'(i_delay));
        n_s2_ctl.half_gain = (i_mode == MODE_REVERB);
        n_s2_ctl.use_self  = (i_delay == '0);
        n_s2_ctl.clip_on   = clip_mode;
    end

    // stage occupancy
    always_comb begin
        if (i_acc) begin
            n_s2_valid = 1'b1;
        end else if (i_move) begin
            n_s2_valid = 1'b0;
        end else begin
            n_s2_valid = r_s2_valid;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx   <= '0;
            r_pos      <= '0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= n_s2_valid;
            if (i_acc) begin
                r_wr_idx <= n_wr_idx;
                r_pos    <= n_pos;
            end
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_s2_sample  <= i_sample;
            r_s2_ctl     <= n_s2_ctl;
            r_s2_wr_addr <= r_wr_idx;
        end
    end

    assign o_s2_valid   = r_s2_valid;
    assign o_s2_sample  = r_s2_sample;
    assign o_s2_ctl     = r_s2_ctl;
    assign o_s2_wr_addr = r_s2_wr_addr;

    // checks
    `ECCL_ASSERT_NXT(a_acc_loads_stage, i_clk, i_rst_n, i_acc, r_s2_valid, "accepted sample lost")
    `ECCL_ASSERT_NXT(a_idx_holds, i_clk, i_rst_n, !i_acc, $stable(r_wr_idx), "write index moved without a transfer")
    `ECCL_ASSERT_NXT(a_pos_counts, i_clk, i_rst_n, i_acc && !i_block_start && (r_pos != POS_MAX), r_pos == POS_BITS'($past(r_pos) + 1'b1), "block position did not advance")
    `ECCL_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, r_s2_valid && !i_move, !i_acc, "held stage overwritten")

endmodule

@@ rtl/core/eccl_effect_dp.sv @@
// ----------------------------------------------------------------------------
// eccl_effect_dp
// arithmetic stage: gain multiply with rounding, saturating sum, threshold
// clip, and the output register
// ----------------------------------------------------------------------------
module eccl_effect_dp import eccl_pkg::*; #(
    parameter int unsigned SAMPLE_BITS = ECCL_SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s2_valid,
    input  logic signed [SAMPLE_BITS-1:0] i_s2_sample,
    input  t_s2_ctl                       i_s2_ctl,
    input  logic signed [SAMPLE_BITS-1:0] i_rd_data,
    input  logic [INTENS_BITS-1:0]        i_intensity,
    input  logic                          i_stall,
    output logic                          o_move,
    output logic [SAMPLE_BITS-1:0]        o_wr_data,
    output logic                          o_valid,
    output logic signed [SAMPLE_BITS-1:0] o_sample_out
);

    localparam int unsigned PW   = SAMPLE_BITS + INTENS_BITS + 1;
    localparam int unsigned SW   = SAMPLE_BITS + 2;
    localparam int unsigned TH_L = (SAMPLE_BITS >= INTENS_BITS) ? SAMPLE_BITS - INTENS_BITS : 0;
    localparam int unsigned TH_R = (SAMPLE_BITS >= INTENS_BITS) ? 0 : INTENS_BITS - SAMPLE_BITS;
    localparam logic signed [SW-1:0] S_MAX = {3'b000, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic signed [SW-1:0] S_MIN = {3'b111, {(SAMPLE_BITS - 1){1'b0}}};

    logic signed [SAMPLE_BITS-1:0] delayed;
    logic signed [PW-1:0]          prod;
    logic signed [PW:0]            bias;
    logic signed [PW:0]            rnd;
    logic signed [PW:0]            shifted;
    logic signed [SW-1:0]          term;
    logic signed [SW-1:0]          s_ext;
    logic signed [SW-1:0]          sum;
    logic [PW-1:0]                 thr_wide;
    logic signed [SW-1:0]          thr;
    logic signed [SW-1:0]          clipped;
    logic [SAMPLE_BITS-1:0]        y;
    logic                          r_out_valid;
    logic                          n_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_sample;

    // clamp to the sample range
    function automatic logic [SAMPLE_BITS-1:0] sat(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] c;
        if (v > S_MAX) begin
            c = S_MAX;
        end else if (v < S_MIN) begin
            c = S_MIN;
        end else begin
            c = v;
        end
        return c[SAMPLE_BITS-1:0];
    endfunction

    // delayed term: gain product rounded half up
    always_comb begin
        delayed = i_s2_ctl.use_self ? i_s2_sample : i_rd_data;
        prod    = delayed * $signed({1'b0, i_intensity});
        bias    = '0;
        if (i_s2_ctl.half_gain) begin
            bias[REV_SHIFT-1] = 1'b1;
        end else begin
            bias[ECHO_SHIFT-1] = 1'b1;
        end
        rnd     = (PW + 1)'(prod) + bias;
        shifted = i_s2_ctl.half_gain ? (rnd >>> REV_SHIFT) : (rnd >>> ECHO_SHIFT);
        term    = SW'(shifted);
        s_ext   = SW'(i_s2_sample);
        sum     = s_ext + term;
    end

    // symmetric clip at the aligned threshold
    always_comb begin
        thr_wide = (PW'(i_intensity) << TH_L) >> TH_R;
        thr      = $signed(SW'(thr_wide));
        if (s_ext > thr) begin
            clipped = thr;
        end else if (s_ext < -thr) begin
            clipped = -thr;
        end else begin
            clipped = s_ext;
        end
    end

    // result select
    always_comb begin
        if (i_s2_ctl.echo_on) begin
            y = sat(sum);
        end else if (i_s2_ctl.clip_on) begin
            y = sat(clipped);
        end else begin
            y = i_s2_sample;
        end
    end

    // output register handshake
    always_comb begin
        o_move = i_s2_valid && (!r_out_valid || !i_stall);
        if (o_move) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_move) begin
            r_out_sample <= $signed(y);
        end
    end

    assign o_wr_data    = y;
    assign o_valid      = r_out_valid;
    assign o_sample_out = r_out_sample;

endmodule

@@ rtl/core/echo_comb_and_clip_effect_core.sv @@
// ----------------------------------------------------------------------------
// echo_comb_and_clip_effect_core
// feedback comb echo and reverb with a symmetric hard limiter
// ----------------------------------------------------------------------------
// The core takes one signed sample per cycle, back to back, while the output
// does not stall, and gives one processed sample for each. An accepted sample
// is registered in the arithmetic stage and then in the output register,
// where an output stall holds it. Throughput is one sample per cycle without
// output stalls, set by the delay line memory, which takes one read and one write per
// sample; a delay of one is served by a bypass from the write port to the
// read port. A stall on the output holds the result while one more sample
// is taken into the arithmetic stage. Configuration writes are applied on
// the edge they arrive and must only happen while no sample is in flight.
// The delay line needs no clearing pass after reset.
// ----------------------------------------------------------------------------
`include "echo_comb_and_clip_effect_core_macros.svh"

module echo_comb_and_clip_effect_core import eccl_pkg::*; #(
    parameter int unsigned DELAY_DEPTH = ECCL_DEPTH_DEF,
    parameter int unsigned SAMPLE_BITS = ECCL_SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // sample input
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_in,
    input  logic                          i_block_start,
    // sample output
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [SAMPLE_BITS-1:0] o_sample_out,
    // register writes
    input  logic                          i_cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0]       i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]      i_cfg_wdata
);

    localparam int unsigned AW = $clog2(DELAY_DEPTH);

    // depth reciprocal and low depth bits for the delay wrap
    localparam logic [RECIP_BITS-1:0] DLY_RECIP = RECIP_BITS'(
        ((64'd1 << RECIP_BITS) + 64'(DELAY_DEPTH) - 64'd1) / 64'(DELAY_DEPTH));
    localparam logic [DELAY_BITS-1:0] DLY_DEPTH_LO = DELAY_BITS'(DELAY_DEPTH);

    logic [MODE_BITS-1:0]          r_mode;
    logic [DELAY_BITS-1:0]         r_delay;
    logic [AW-1:0]                 r_dmod;
    logic [INTENS_BITS-1:0]        r_intensity;
    logic                          acc;
    logic                          move;
    logic [AW-1:0]                 rd_addr;
    logic                          s2_valid;
    logic signed [SAMPLE_BITS-1:0] s2_sample;
    t_s2_ctl                       s2_ctl;
    logic [AW-1:0]                 s2_wr_addr;
    logic [SAMPLE_BITS-1:0]        rd_data;
    logic [SAMPLE_BITS-1:0]        wr_data;

    // register file, delay wrapped to the line depth on write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= '0;
            r_delay     <= '0;
            r_dmod      <= '0;
            r_intensity <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_MODE: begin
                    r_mode <= i_cfg_wdata[MODE_BITS-1:0];
                end
                CFG_DELAY: begin
                    r_delay <= i_cfg_wdata[DELAY_BITS-1:0];
                    r_dmod  <= AW'(delay_wrap(i_cfg_wdata[DELAY_BITS-1:0],
                                              DLY_DEPTH_LO, DLY_RECIP));
                end
                CFG_INTENSITY: begin
                    r_intensity <= i_cfg_wdata[INTENS_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // input transfer while the arithmetic stage is free or draining
    assign o_stall = s2_valid && !move;
    assign acc     = i_valid && !o_stall;

    eccl_seq #(
        .DELAY_DEPTH (DELAY_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_acc         (acc),
        .i_move        (move),
        .i_sample      (i_sample_in),
        .i_block_start (i_block_start),
        .i_mode        (r_mode),
        .i_delay       (r_delay),
        .i_dmod        (r_dmod),
        .o_rd_addr     (rd_addr),
        .o_s2_valid    (s2_valid),
        .o_s2_sample   (s2_sample),
        .o_s2_ctl      (s2_ctl),
        .o_s2_wr_addr  (s2_wr_addr)
    );

    eccl_delay_mem #(
        .DEPTH (DELAY_DEPTH),
        .WIDTH (SAMPLE_BITS)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (acc),
        .i_rd_addr (rd_addr),
        .i_wr_en   (move),
        .i_wr_addr (s2_wr_addr),
        .i_wr_data (wr_data),
        .o_rd_data (rd_data)
    );

    eccl_effect_dp #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s2_valid   (s2_valid),
        .i_s2_sample  (s2_sample),
        .i_s2_ctl     (s2_ctl),
        .i_rd_data    ($signed(rd_data)),
        .i_intensity  (r_intensity),
        .i_stall      (i_stall),
        .o_move       (move),
        .o_wr_data    (wr_data),
        .o_valid      (o_valid),
        .o_sample_out (o_sample_out)
    );

endmodule

@@ dv/tb_echo_comb_and_clip_effect_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_echo_comb_and_clip_effect_core
// self-checking bench for the echo, reverb and clip core
// ----------------------------------------------------------------------------
// Each accepted sample runs through a local comb and clip predictor, which
// keeps its own delay line, write pointer, block position and register copy.
// The expected output goes into a queue and every output transfer is checked
// against the oldest entry. A short table of hand-worked samples comes first,
// then random phases, each with its own register setting. One long phase
// lets the echo arrive from a delay of a couple of hundred samples. Both
// sides idle at random: the source in bursts, the sink on a stall pattern
// of its own.
// ----------------------------------------------------------------------------
module tb_echo_comb_and_clip_effect_core;
    import eccl_pkg::*;

    localparam int unsigned SB    = ECCL_SAMPLE_BITS_DEF;
    localparam int unsigned DEPTH = ECCL_DEPTH_DEF;

    localparam logic signed [SB-1:0] SMP_MAX = {1'b0, {(SB-1){1'b1}}};
    localparam logic signed [SB-1:0] SMP_MIN = {1'b1, {(SB-1){1'b0}}};

    // mode codes with no name in the package
    localparam logic [MODE_BITS-1:0] MODE_NONE     = 3'd0;
    localparam logic [MODE_BITS-1:0] MODE_SPARE_LO = 3'd5;
    localparam logic [MODE_BITS-1:0] MODE_SPARE_HI = 3'd7;

    // index with no register behind it
    localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 2'd3;

    localparam logic [INTENS_BITS-1:0] GAIN_ONE   = 16'h8000;
    localparam logic [INTENS_BITS-1:0] GAIN_HALF  = 16'h4000;
    localparam logic [DELAY_BITS-1:0]  DELAY_TOP  = 12'hFFF;
    localparam logic [DELAY_BITS-1:0]  LONG_DELAY = 12'd200;

    // directed stimulus row; want is only used when chk is set
    typedef struct packed {
        logic [MODE_BITS-1:0]   mode;
        logic [DELAY_BITS-1:0]  delay;
        logic [INTENS_BITS-1:0] gain;
        logic [SB-1:0]          smp;
        logic                   bs;
        logic                   chk;
        logic [SB-1:0]          want;
    } t_dir_row;

    localparam int unsigned N_DIR = 25;
    localparam t_dir_row DIR_ROWS [N_DIR] = '{
        // pass through after reset and in spare modes
        '{MODE_NONE,     12'd0, 16'd0,     24'h7FFFFF, 1'b1, 1'b1, 24'h7FFFFF},
        '{MODE_NONE,     12'd0, 16'd0,     24'h800000, 1'b0, 1'b1, 24'h800000},
        '{MODE_SPARE_HI, 12'd0, 16'd0,     24'h123456, 1'b0, 1'b1, 24'h123456},
        '{MODE_SPARE_LO, 12'd0, 16'd0,     24'hFFFFFF, 1'b0, 1'b1, 24'hFFFFFF},
        // symmetric clipping at half scale
        '{MODE_COMP,     12'd0, GAIN_HALF, 24'h7FFFFF, 1'b0, 1'b1, 24'h400000},
        '{MODE_COMP,     12'd0, GAIN_HALF, 24'h800000, 1'b0, 1'b1, 24'hC00000},
        '{MODE_LIMIT,    12'd0, GAIN_HALF, 24'd1000,   1'b0, 1'b1, 24'd1000},
        // zero threshold and full-scale threshold
        '{MODE_LIMIT,    12'd0, 16'd0,     24'd5,      1'b0, 1'b1, 24'd0},
        '{MODE_LIMIT,    12'd0, 16'd0,     24'hFFFFFB, 1'b0, 1'b1, 24'd0},
        '{MODE_LIMIT,    12'd0, GAIN_ONE,  24'h800000, 1'b0, 1'b1, 24'h800000},
        '{MODE_LIMIT,    12'd0, GAIN_ONE,  24'h7FFFFF, 1'b0, 1'b1, 24'h7FFFFF},
        // zero delay: sample times one plus gain, saturated
        '{MODE_ECHO,     12'd0, GAIN_ONE,  24'h100000, 1'b0, 1'b1, 24'h200000},
        '{MODE_ECHO,     12'd0, GAIN_ONE,  24'h7FFFFF, 1'b0, 1'b1, 24'h7FFFFF},
        '{MODE_ECHO,     12'd0, GAIN_ONE,  24'h800000, 1'b0, 1'b1, 24'h800000},
        // reverb halves the gain, a half rounds upwards
        '{MODE_REVERB,   12'd0, GAIN_ONE,  24'd4,      1'b0, 1'b1, 24'd6},
        '{MODE_REVERB,   12'd0, GAIN_ONE,  24'hFFFFFD, 1'b0, 1'b1, 24'hFFFFFC},
        // block start, early in block, then the first echo
        '{MODE_ECHO,     12'd3, GAIN_HALF, 24'd100,    1'b1, 1'b1, 24'd100},
        '{MODE_ECHO,     12'd3, GAIN_HALF, 24'd200,    1'b0, 1'b1, 24'd200},
        '{MODE_ECHO,     12'd3, GAIN_HALF, 24'd300,    1'b0, 1'b1, 24'd300},
        '{MODE_ECHO,     12'd3, GAIN_HALF, 24'd0,      1'b0, 1'b1, 24'd50},
        // delay of one goes through the write-to-read bypass
        '{MODE_ECHO,     12'd1, GAIN_HALF, 24'd1000,   1'b1, 1'b1, 24'd1000},
        '{MODE_ECHO,     12'd1, GAIN_HALF, 24'd0,      1'b0, 1'b1, 24'd500},
        '{MODE_ECHO,     12'd1, GAIN_HALF, 24'd0,      1'b0, 1'b1, 24'd250},
        '{MODE_REVERB,   12'd1, GAIN_ONE,  24'hFFFFFF, 1'b0, 1'b0, 24'd0},
        // deepest delay, still early in the block
        '{MODE_ECHO,     DELAY_TOP, GAIN_ONE, 24'd12345, 1'b1, 1'b1, 24'd12345}
    };

    // dut ports
    logic                     i_clk         = 1'b0;
    logic                     i_rst_n       = 1'b0;
    logic                     i_valid       = 1'b0;
    logic                     o_stall;
    logic signed [SB-1:0]     i_sample_in   = '0;
    logic                     i_block_start = 1'b0;
    logic                     o_valid;
    logic                     i_stall       = 1'b0;
    logic signed [SB-1:0]     o_sample_out;
    logic                     i_cfg_wr_en   = 1'b0;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_wdata   = '0;

    // typed expectation travelling alongside the driven sample
    logic                 typed_chk = 1'b0;
    logic signed [SB-1:0] typed_exp = '0;

    // predictor state and register copy
    logic signed [SB-1:0]   echo_mem [DEPTH];
    int unsigned            wr_ptr    = 0;
    int unsigned            blk_pos   = 0;
    logic [MODE_BITS-1:0]   cfg_mode  = MODE_NONE;
    logic [DELAY_BITS-1:0]  cfg_delay = '0;
    logic [INTENS_BITS-1:0] cfg_gain  = '0;

    logic signed [SB-1:0] expected_samples [$];
    int unsigned          mismatches = 0;

    // source burst control
    bit          steady_feed = 1'b0;
    int unsigned burst_left  = 0;

    // sink stall pattern
    int unsigned stall_style = 0;
    int unsigned stall_left  = 0;
    int unsigned stall_tick  = 0;

    echo_comb_and_clip_effect_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_sample_in   (i_sample_in),
        .i_block_start (i_block_start),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_sample_out  (o_sample_out),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // comb and clip predictor: one output per sample, state advances
    function automatic logic signed [SB-1:0] comb_clip_predict(
        input logic signed [SB-1:0] smp,
        input logic                 bs
    );
        longint      s;
        longint      y;
        longint      dly;
        longint      term;
        longint      thr;
        int unsigned pos;
        int unsigned sh;
        s   = smp;
        y   = s;
        pos = bs ? 0 : blk_pos;
        if (cfg_mode == MODE_REVERB || cfg_mode == MODE_ECHO) begin
            if (pos >= cfg_delay) begin
                if (cfg_delay == 0) begin
                    dly = s;
                end else begin
                    dly = echo_mem[(wr_ptr + DEPTH - cfg_delay) % DEPTH];
                end
                sh   = (cfg_mode == MODE_REVERB) ? REV_SHIFT : ECHO_SHIFT;
                term = (dly * longint'(cfg_gain) + (longint'(1) << (sh - 1))) >>> sh;
                y    = s + term;
                if (y > longint'(SMP_MAX)) y = SMP_MAX;
                if (y < longint'(SMP_MIN)) y = SMP_MIN;
            end
        end else if (cfg_mode == MODE_COMP || cfg_mode == MODE_LIMIT) begin
            thr = longint'(cfg_gain) << (SB - 16);
            if (s > thr) y = thr;
            else if (s < -thr) y = -thr;
        end
        echo_mem[wr_ptr] = y[SB-1:0];
        wr_ptr  = (wr_ptr + 1) % DEPTH;
        blk_pos = (pos < POS_MAX) ? pos + 1 : POS_MAX;
        return y[SB-1:0];
    endfunction

    // input and output transfers
    always @(posedge i_clk) begin
        logic signed [SB-1:0] exp_smp;
        logic signed [SB-1:0] pred;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                pred = comb_clip_predict(i_sample_in, i_block_start);
                expected_samples.push_back(typed_chk ? typed_exp : pred);
            end
            if (o_valid && !i_stall) begin
                if (expected_samples.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected output transfer: sample_out %0d",
                                 o_sample_out);
                end else begin
                    exp_smp = expected_samples.pop_front();
                    if (o_sample_out !== exp_smp) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("sample_out mismatch: expected %0d got %0d",
                                     exp_smp, o_sample_out);
                    end
                end
            end
        end
    end

    // sink stall pattern, restyled at random intervals
    always @(posedge i_clk) begin
        stall_tick <= stall_tick + 1;
        if (stall_left == 0) begin
            stall_style <= $urandom_range(0, 3);
            stall_left  <= $urandom_range(16, 96);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_style)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 3) == 0);
            2: i_stall <= ($urandom_range(0, 9) < 6);
            default: i_stall <= (stall_tick % 5 == 0);
        endcase
    end

    // one sample transfer, with a gap between bursts unless the feed is steady
    task automatic send_sample(
        input logic signed [SB-1:0] smp,
        input logic                 bs,
        input logic                 chk,
        input logic signed [SB-1:0] want
    );
        int unsigned gap;
        gap = 0;
        if (!steady_feed) begin
            if (burst_left == 0) begin
                gap        = $urandom_range(1, 7);
                burst_left = $urandom_range(1, 24);
            end else begin
                burst_left--;
            end
        end
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_sample_in   <= smp;
        i_block_start <= bs;
        typed_chk     <= chk;
        typed_exp     <= want;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // wait until nothing is in flight; the last input transfer is queued
    // before the queue is watched
    task automatic drain_pipe();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_samples.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // register write, enable left high for a following write
    task automatic write_reg(
        input logic [CFG_IDX_BITS-1:0]  idx,
        input logic [CFG_DATA_BITS-1:0] data
    );
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        case (idx)
            CFG_MODE:      cfg_mode  = data[MODE_BITS-1:0];
            CFG_DELAY:     cfg_delay = data[DELAY_BITS-1:0];
            CFG_INTENSITY: cfg_gain  = data[INTENS_BITS-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // new effect setting, unused upper data bits carry noise
    task automatic program_effect(
        input logic [MODE_BITS-1:0]   mode,
        input logic [DELAY_BITS-1:0]  delay,
        input logic [INTENS_BITS-1:0] gain
    );
        drain_pipe();
        write_reg(CFG_MODE, (16'($urandom) & ~16'h0007) | 16'(mode));
        write_reg(CFG_DELAY, (16'($urandom) & ~16'h0FFF) | 16'(delay));
        if ($urandom_range(0, 3) == 0) write_reg(CFG_UNUSED, 16'($urandom));
        write_reg(CFG_INTENSITY, gain);
        i_cfg_wr_en <= 1'b0;
    endtask

    function automatic logic signed [SB-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return SMP_MAX;
            1: return SMP_MIN;
            2: return SB'($signed($urandom_range(0, 510)) - 255);
            3: return SB'($signed($urandom_range(0, 2)) - 1);
            default: return SB'($urandom);
        endcase
    endfunction

    function automatic logic [INTENS_BITS-1:0] pick_gain();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return GAIN_ONE;
            default: return INTENS_BITS'($urandom_range(0, GAIN_ONE));
        endcase
    endfunction

    // a phase of random samples under a random setting
    task automatic random_phase();
        logic [MODE_BITS-1:0]  mode;
        logic [DELAY_BITS-1:0] delay;
        int unsigned           n;
        case ($urandom_range(0, 9))
            0, 1, 2: mode = MODE_ECHO;
            3, 4:    mode = MODE_REVERB;
            5:       mode = MODE_COMP;
            6:       mode = MODE_LIMIT;
            7:       mode = MODE_NONE;
            default: mode = MODE_BITS'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
        endcase
        case ($urandom_range(0, 9))
            0:       delay = '0;
            1:       delay = 12'd1;
            7, 8:    delay = DELAY_BITS'($urandom_range(17, 120));
            9:       delay = DELAY_TOP;
            default: delay = DELAY_BITS'($urandom_range(2, 16));
        endcase
        program_effect(mode, delay, pick_gain());
        steady_feed = ($urandom_range(0, 3) == 0);
        n = $urandom_range(40, 90);
        for (int k = 0; k < n; k++) begin
            send_sample(pick_sample(),
                        (k == 0) ? 1'($urandom) : ($urandom_range(0, 59) == 0),
                        1'b0, '0);
        end
    endtask

    // stimulus
    initial begin
        for (int k = 0; k < DEPTH; k++) echo_mem[k] = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // hand-worked table
        for (int r = 0; r < N_DIR; r++) begin
            if (DIR_ROWS[r].mode != cfg_mode || DIR_ROWS[r].delay != cfg_delay ||
                DIR_ROWS[r].gain != cfg_gain)
                program_effect(DIR_ROWS[r].mode, DIR_ROWS[r].delay, DIR_ROWS[r].gain);
            send_sample(DIR_ROWS[r].smp, DIR_ROWS[r].bs, DIR_ROWS[r].chk,
                        DIR_ROWS[r].want);
        end

        repeat (5) random_phase();

        // one long block so an echo from a long delay arrives
        program_effect(MODE_ECHO, LONG_DELAY,
                       INTENS_BITS'($urandom_range(GAIN_HALF, GAIN_ONE)));
        steady_feed = 1'b0;
        for (int k = 0; k < int'(LONG_DELAY) + 30; k++)
            send_sample(pick_sample(), (k == 0), 1'b0, '0);

        repeat (5) random_phase();

        drain_pipe();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && expected_samples.size() == 0) begin
            $display("tb_echo_comb_and_clip_effect_core OK");
        end else begin
            $display("tb_echo_comb_and_clip_effect_core NOT OK");
        end
        $finish;
    end

    // run limit
    initial begin
        #20_000_000;
        $display("tb_echo_comb_and_clip_effect_core NOT OK");
        $finish;
    end

endmodule
